@@ src/date_pair_day_distance_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the date pair day distance core
// Each macro takes a label, an antecedent, a consequent and a message.
// ----------------------------------------------------------------------------
`ifndef DATE_PAIR_DAY_DISTANCE_CORE_MACROS_SVH
`define DATE_PAIR_DAY_DISTANCE_CORE_MACROS_SVH

// Consequent checked at the same clock edge as the antecedent.
`define DPDD_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked from the next clock edge on.
`define DPDD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/dpdd_pkg.sv @@
// ----------------------------------------------------------------------------
// dpdd_pkg
// Types, widths and calendar tables shared by the day distance core.
// ----------------------------------------------------------------------------
`default_nettype none

package dpdd_pkg;

    localparam int DayW   = 5;
    localparam int MonthW = 4;
    localparam int YearW  = 16;
    localparam int DistW  = 25;
    localparam int BeforeW = 9;

    // year / 4 fits in this many bits
    localparam int QuoW   = YearW - 2;
    localparam int CentW  = 10;

    localparam int YearDays = 365;

    // x / 25 == (x * Div25Mul) >> Div25Shift for every x below 2**QuoW.
    localparam int Div25Mul   = 5243;
    localparam int Div25Shift = 17;
    localparam int ProdW      = QuoW + 13;

    localparam logic [MonthW-1:0] MonthJan = 4'd1;
    localparam logic [MonthW-1:0] MonthFeb = 4'd2;
    localparam logic [MonthW-1:0] MonthDec = 4'd12;

    typedef struct packed {
        logic [DayW-1:0]   day;
        logic [MonthW-1:0] month;
        logic [YearW-1:0]  year;
    } t_date;

    typedef struct packed {
        logic             valid;
        logic [DistW-1:0] number;
    } t_day_info;

    function automatic logic [ProdW-1:0] div25_prod(input logic [QuoW-1:0] x);
        return ProdW'(x) * ProdW'(Div25Mul);
    endfunction

    // Days of all months before the given one; month zero counts none and
    // months above twelve count the whole year.
    function automatic logic [BeforeW-1:0] days_before(input logic [MonthW-1:0] m);
        logic [BeforeW-1:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd365;
        endcase
        return d;
    endfunction

    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                   input logic leap);
        logic [DayW-1:0] len;
        case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            MonthFeb:                len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

@@ src/date_pair_day_distance_core.sv @@
// Pipeline: a result strobes on o_done once the date pair has passed the input
// register, the two conversion stages per date and the result register.
// Throughput: one date pair every cycle; busy is high only during reset and in
// the cycle after it. Results cannot be held off, so nothing stalls the pipeline.
// Reset (synchronous, active low) clears r_target and the pipeline valid flags.
// ----------------------------------------------------------------------------
// date_pair_day_distance_core
// Checks two Gregorian dates and gives the day distance between them and a
// match flag against a configured target distance.
// ----------------------------------------------------------------------------
`default_nettype none

`include "date_pair_day_distance_core_macros.svh"

module date_pair_day_distance_core (
    input  wire                          i_clk,
    input  wire                          i_rst_n,

    input  wire                          start,
    output logic                         busy,
    input  wire [dpdd_pkg::DayW-1:0]     i_day_a,
    input  wire [dpdd_pkg::MonthW-1:0]   i_month_a,
    input  wire [dpdd_pkg::YearW-1:0]    i_year_a,
    input  wire [dpdd_pkg::DayW-1:0]     i_day_b,
    input  wire [dpdd_pkg::MonthW-1:0]   i_month_b,
    input  wire [dpdd_pkg::YearW-1:0]    i_year_b,

    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [dpdd_pkg::DistW-1:0]    i_cfg_data,

    output logic                         o_done,
    output logic                         o_valid_a,
    output logic                         o_valid_b,
    output logic [dpdd_pkg::DistW-1:0]   o_day_distance,
    output logic                         o_is_match
);

    logic                       r_ready;
    logic [dpdd_pkg::DistW-1:0] r_target;

    logic                       accept;
    dpdd_pkg::t_date            r_date_a;
    dpdd_pkg::t_date            r_date_b;
    logic                       r_in_vld;
    logic                       r_p1_vld;
    logic                       r_p2_vld;

    dpdd_pkg::t_day_info        info_a;
    dpdd_pkg::t_day_info        info_b;

    logic [dpdd_pkg::DistW-1:0] n_dist;
    logic                       n_match;

    logic                       r_done;
    logic                       r_valid_a;
    logic                       r_valid_b;
    logic [dpdd_pkg::DistW-1:0] r_dist;
    logic                       r_match;

    assign busy        = !r_ready;
    assign o_cfg_ready = r_ready;
    assign accept      = start && r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready  <= 1'b0;
            r_target <= '0;
        end else begin
            r_ready <= 1'b1;
            if (i_cfg_valid && r_ready) begin
                r_target <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_in_vld <= accept;
            r_p1_vld <= r_in_vld;
            r_p2_vld <= r_p1_vld;
            r_done   <= r_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_date_a <= {i_day_a, i_month_a, i_year_a};
            r_date_b <= {i_day_b, i_month_b, i_year_b};
        end
    end

    dpdd_date_conv u_conv_a (
        .i_clk  (i_clk),
        .i_date (r_date_a),
        .o_info (info_a)
    );

    dpdd_date_conv u_conv_b (
        .i_clk  (i_clk),
        .i_date (r_date_b),
        .o_info (info_b)
    );

    always_comb begin
        if (info_a.number >= info_b.number) begin
            n_dist = info_a.number - info_b.number;
        end else begin
            n_dist = info_b.number - info_a.number;
        end
        n_match = info_a.valid && info_b.valid && (n_dist == r_target);
    end

    always_ff @(posedge i_clk) begin
        r_valid_a <= info_a.valid;
        r_valid_b <= info_b.valid;
        r_dist    <= n_dist;
        r_match   <= n_match;
    end

    assign o_done         = r_done;
    assign o_valid_a      = r_valid_a;
    assign o_valid_b      = r_valid_b;
    assign o_day_distance = r_dist;
    assign o_is_match     = r_match;

    `DPDD_ASSERT_NEXT(a_word_to_result, start && !busy, ##3 o_done, "accepted word gave no result")
    `DPDD_ASSERT_NOW(a_result_has_word, o_done, $past(start && !busy, 4), "result without a word")
    `DPDD_ASSERT_NOW(a_match_needs_valid, o_done && o_is_match, o_valid_a && o_valid_b, "match on invalid date")

endmodule

`default_nettype wire

@@ src/dpdd_date_conv.sv @@
// ----------------------------------------------------------------------------
// dpdd_date_conv
// Two-stage date check and day number conversion for one date.
// ----------------------------------------------------------------------------
`default_nettype none

module dpdd_date_conv (
    input  wire                 i_clk,
    input  dpdd_pkg::t_date     i_date,
    output dpdd_pkg::t_day_info o_info
);

    logic [dpdd_pkg::YearW-1:0]   g_year;
    logic [dpdd_pkg::ProdW-1:0]   py4;
    logic [dpdd_pkg::ProdW-1:0]   py16;
    logic [dpdd_pkg::ProdW-1:0]   pg4;
    logic [dpdd_pkg::ProdW-1:0]   pg16;
    logic                         div100;
    logic                         div400;
    logic                         leap;
    logic                         n_valid;

    logic [dpdd_pkg::QuoW-1:0]    r_q4;
    logic [dpdd_pkg::CentW-1:0]   r_q100;
    logic [dpdd_pkg::CentW-1:0]   r_q400;
    logic [dpdd_pkg::DistW-1:0]   r_y365;
    logic [dpdd_pkg::BeforeW-1:0] r_before;
    logic [dpdd_pkg::DayW-1:0]    r_day;
    logic                         r_valid;

    logic [dpdd_pkg::QuoW-1:0]    leaps;
    logic [dpdd_pkg::DistW-1:0]   n_number;
    dpdd_pkg::t_day_info          r_info;

    // Stage 1: divisions by 4, 100 and 400 and the validity check.
    always_comb begin
        py4  = dpdd_pkg::div25_prod(i_date.year[dpdd_pkg::YearW-1:2]);
        py16 = dpdd_pkg::div25_prod({2'b00, i_date.year[dpdd_pkg::YearW-1:4]});

        // The low product bits stay below the multiplier exactly when the
        // operand is a multiple of 25.
        div100 = (i_date.year[1:0] == 2'b00) &&
                 (py4[dpdd_pkg::Div25Shift-1:0] < dpdd_pkg::Div25Shift'(dpdd_pkg::Div25Mul));
        div400 = (i_date.year[3:0] == 4'b0000) &&
                 (py16[dpdd_pkg::Div25Shift-1:0] < dpdd_pkg::Div25Shift'(dpdd_pkg::Div25Mul));
        leap   = (i_date.year[1:0] == 2'b00) && (!div100 || div400);

        n_valid = (i_date.year != '0) && (i_date.day != '0) &&
                  (i_date.month >= dpdd_pkg::MonthJan) &&
                  (i_date.month <= dpdd_pkg::MonthDec) &&
                  (i_date.day <= dpdd_pkg::month_len(i_date.month, leap));

        // January, February and month zero count leap days through the year
        // before; year zero there has none.
        if (i_date.month <= dpdd_pkg::MonthFeb) begin
            g_year = (i_date.year == '0) ? '0 : i_date.year - 16'd1;
        end else begin
            g_year = i_date.year;
        end
        pg4  = dpdd_pkg::div25_prod(g_year[dpdd_pkg::YearW-1:2]);
        pg16 = dpdd_pkg::div25_prod({2'b00, g_year[dpdd_pkg::YearW-1:4]});
    end

    always_ff @(posedge i_clk) begin
        r_q4     <= g_year[dpdd_pkg::YearW-1:2];
        r_q100   <= pg4[dpdd_pkg::Div25Shift +: dpdd_pkg::CentW];
        r_q400   <= pg16[dpdd_pkg::Div25Shift +: dpdd_pkg::CentW];
        r_y365   <= dpdd_pkg::DistW'(i_date.year) * dpdd_pkg::DistW'(dpdd_pkg::YearDays);
        r_before <= dpdd_pkg::days_before(i_date.month);
        r_day    <= i_date.day;
        r_valid  <= n_valid;
    end

    // Stage 2: sum up the day number.
    always_comb begin
        leaps    = r_q4 - dpdd_pkg::QuoW'(r_q100) + dpdd_pkg::QuoW'(r_q400);
        n_number = r_y365 + dpdd_pkg::DistW'(r_before) + dpdd_pkg::DistW'(r_day) +
                   dpdd_pkg::DistW'(leaps);
    end

    always_ff @(posedge i_clk) begin
        r_info.valid  <= r_valid;
        r_info.number <= n_number;
    end

    assign o_info = r_info;

endmodule

`default_nettype wire
